>>> rtl/dmpt_pkg.sv
// Shared types, constants and index functions for the partial trace block.
package dmpt_pkg;

   localparam int MAX_QUBITS = 6;
   localparam int QB_W       = $clog2(MAX_QUBITS);
   localparam int QCNT_W     = 3;
   localparam int MASK_W     = 6;
   localparam int POS_W      = 2 * MAX_QUBITS;
   localparam int ACC_DEPTH  = 1 << POS_W;
   localparam int ELEM_W     = 24;
   localparam int SUM_W      = 32;
   localparam int ACC_W      = 2 * SUM_W;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   // register decode uses the word address bit
   localparam logic REG_QUBIT_COUNT = 1'b0;
   localparam logic REG_TRACE_MASK  = 1'b1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef struct packed {
      logic                     kind;
      logic signed [ELEM_W-1:0] elem_real;
      logic signed [ELEM_W-1:0] elem_imag;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum_real;
      logic signed [SUM_W-1:0] sum_imag;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [QCNT_W-1:0] qubit_count;
      logic [MASK_W-1:0] trace_mask;
   } cfg_type;

   typedef struct packed {
      logic                     drain;
      logic                     wr;
      logic [POS_W-1:0]         addr;
      logic                     last;
      logic signed [ELEM_W-1:0] elem_real;
      logic signed [ELEM_W-1:0] elem_imag;
   } op_type;

   typedef struct packed {
      logic s1_valid;
      logic s1_drain;
      logic clearing;
   } acc_status_type;

   function automatic logic [QCNT_W-1:0] eff_n(logic [QCNT_W-1:0] count);
      logic [QCNT_W-1:0] n;
      n = count;
      if (count == '0) begin
         n = QCNT_W'(1);
      end else if (count > QCNT_W'(MAX_QUBITS)) begin
         n = QCNT_W'(MAX_QUBITS);
      end
      return n;
   endfunction

   // qubit q maps to index bit n-1-q
   function automatic logic [MAX_QUBITS-1:0] traced_bits(logic [QCNT_W-1:0] n,
                                                          logic [MASK_W-1:0] mask);
      logic [MAX_QUBITS-1:0] tb;
      tb = '0;
      for (int q = 0; q < MAX_QUBITS; q++) begin
         if ((q < int'(n)) && mask[q]) begin
            tb[QB_W'(int'(n) - 1 - q)] = 1'b1;
         end
      end
      return tb;
   endfunction

   function automatic logic [QCNT_W-1:0] kept_count(logic [QCNT_W-1:0] n,
                                                     logic [MAX_QUBITS-1:0] tb);
      logic [QCNT_W-1:0] c;
      c = '0;
      for (int b = 0; b < MAX_QUBITS; b++) begin
         if ((b < int'(n)) && !tb[b]) begin
            c = c + QCNT_W'(1);
         end
      end
      return c;
   endfunction

   function automatic logic [MAX_QUBITS-1:0] compact(logic [MAX_QUBITS-1:0] idx,
                                                     logic [QCNT_W-1:0] n,
                                                     logic [MAX_QUBITS-1:0] tb);
      logic [MAX_QUBITS-1:0] out_bits;
      logic [QB_W-1:0]       pos;
      out_bits = '0;
      pos      = '0;
      for (int b = 0; b < MAX_QUBITS; b++) begin
         if ((b < int'(n)) && !tb[b]) begin
            out_bits[pos] = idx[b];
            pos = pos + QB_W'(1);
         end
      end
      return out_bits;
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] acc,
                                                logic [ELEM_W-1:0] elem);
      logic [SUM_W:0] s;
      logic [SUM_W-1:0] r;
      s = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - ELEM_W){elem[ELEM_W-1]}}, elem};
      r = s[SUM_W-1:0];
      if (s[SUM_W] != s[SUM_W-1]) begin
         r = s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
      end
      return r;
   endfunction

endpackage

>>> rtl/density_matrix_partial_trace.sv
// Top level of the streaming density matrix partial trace block.
// Load transactions stream the 2^n x 2^n matrix in row-major order; each
// element whose row and column agree on the traced qubits is added, with
// 32-bit saturation, into the reduced matrix at the compacted (row, col)
// position. Drain transactions read the reduced matrix in row-major order,
// one element each, clear it, and flag the final element with last. The
// block takes one transaction per cycle unless stalled: each one does a single
// read-modify-write of the 4096-entry accumulator memory (one read port,
// one write port), with a forwarding path for back-to-back updates to the
// same entry. A drain result passes from the read-modify-write stage into
// the response register when that stage advances, which raises rsp_valid;
// loads give no response. The response register frees the request side,
// so loads keep flowing while a result waits; a drain only stalls when the
// previous result is still held. After reset the accumulators are zeroed
// by a clearing pass over all 4096 entries during which req_ready stays
// low (register writes still work). Any register write restarts the load
// and drain positions at zero and keeps the accumulators; write registers
// only while the block is idle.
module density_matrix_partial_trace (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  dmpt_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output dmpt_pkg::rsp_type            rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [dmpt_pkg::PADDR_W-1:0] paddr,
   input  logic [dmpt_pkg::PDATA_W-1:0] pwdata,
   output logic [dmpt_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);

   dmpt_pkg::cfg_type        cfg;
   dmpt_pkg::op_type         op;
   dmpt_pkg::acc_status_type status;
   dmpt_pkg::rsp_type        result;
   dmpt_pkg::rsp_type        rsp_data_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     restart;
   logic                     accept;
   logic                     adv;
   logic                     emit;

   // Register file; any write restarts both positions.
   dmpt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .restart (restart)
   );

   // Advance the stage unless it holds a drain result with nowhere to go.
   assign adv = status.s1_valid &&
                (!status.s1_drain || !rsp_valid_ff || rsp_ready);

   // Take a transaction when the clearing pass is done and the stage frees up.
   assign req_ready = !status.clearing && (!status.s1_valid || adv);
   assign accept    = req_valid && req_ready;
   assign emit      = adv && status.s1_drain;

   // Map the position counters to an accumulator address.
   dmpt_index u_index (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .restart (restart),
      .accept  (accept),
      .req     (req_data),
      .op      (op)
   );

   // Read the entry at accept, update it and write it back when the stage advances.
   dmpt_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .op     (op),
      .adv    (adv),
      .status (status),
      .result (result)
   );

   // Response register: load on a finished drain, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload until the next drain result arrives.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/dmpt_csr.sv
// Configuration registers behind the APB-style port.
module dmpt_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dmpt_pkg::PADDR_W-1:0]   paddr,
   input  logic [dmpt_pkg::PDATA_W-1:0]   pwdata,
   output logic [dmpt_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready,
   output dmpt_pkg::cfg_type              cfg,
   output logic                           restart
);

   logic [dmpt_pkg::QCNT_W-1:0] qubit_count_ff;
   logic [dmpt_pkg::QCNT_W-1:0] qubit_count_in;
   logic [dmpt_pkg::MASK_W-1:0] trace_mask_ff;
   logic [dmpt_pkg::MASK_W-1:0] trace_mask_in;
   logic                        wr_en;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign restart = wr_en;

   always_comb begin
      qubit_count_in = qubit_count_ff;
      trace_mask_in  = trace_mask_ff;
      if (wr_en) begin
         case (paddr[2])
            dmpt_pkg::REG_QUBIT_COUNT: qubit_count_in = pwdata[dmpt_pkg::QCNT_W-1:0];
            dmpt_pkg::REG_TRACE_MASK:  trace_mask_in  = pwdata[dmpt_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qubit_count_ff <= dmpt_pkg::QCNT_W'(1);
         trace_mask_ff  <= '0;
      end else begin
         qubit_count_ff <= qubit_count_in;
         trace_mask_ff  <= trace_mask_in;
      end
   end

   always_comb begin
      case (paddr[2])
         dmpt_pkg::REG_QUBIT_COUNT:
            prdata = dmpt_pkg::PDATA_W'(qubit_count_ff);
         dmpt_pkg::REG_TRACE_MASK:
            prdata = dmpt_pkg::PDATA_W'(trace_mask_ff);
         default:
            prdata = '0;
      endcase
   end

   assign cfg.qubit_count = qubit_count_ff;
   assign cfg.trace_mask  = trace_mask_ff;

endmodule

>>> rtl/dmpt_index.sv
// Load and drain position counters and reduced-matrix address generation.
module dmpt_index (
   input  logic              clock,
   input  logic              reset,
   input  dmpt_pkg::cfg_type cfg,
   input  logic              restart,
   input  logic              accept,
   input  dmpt_pkg::req_type req,
   output dmpt_pkg::op_type  op
);

   localparam int NQ = dmpt_pkg::MAX_QUBITS;
   localparam int PW = dmpt_pkg::POS_W;

   logic [PW-1:0]               load_pos_ff;
   logic [PW-1:0]               load_pos_in;
   logic [PW-1:0]               drain_pos_ff;
   logic [PW-1:0]               drain_pos_in;
   logic [dmpt_pkg::QCNT_W-1:0] n;
   logic [dmpt_pkg::QCNT_W-1:0] m;
   logic [NQ-1:0]               tb;
   logic [NQ-1:0]               dmask;
   logic [PW-1:0]               smask;
   logic [PW-1:0]               rmask;
   logic [PW-1:0]               lp;
   logic [PW-1:0]               dp;
   logic [NQ-1:0]               row;
   logic [NQ-1:0]               col;
   logic [NQ-1:0]               k;
   logic [NQ-1:0]               l;
   logic                        hit;
   logic                        drain;

   always_comb begin
      n     = dmpt_pkg::eff_n(cfg.qubit_count);
      tb    = dmpt_pkg::traced_bits(n, cfg.trace_mask);
      m     = dmpt_pkg::kept_count(n, tb);
      dmask = ~({NQ{1'b1}} << n);
      smask = ~({PW{1'b1}} << {n, 1'b0});
      rmask = ~({PW{1'b1}} << {m, 1'b0});
      lp    = load_pos_ff & smask;
      dp    = drain_pos_ff & rmask;
      row   = NQ'(lp >> n) & dmask;
      col   = lp[NQ-1:0] & dmask;
      hit   = (row & tb) == (col & tb);
      k     = dmpt_pkg::compact(row, n, tb);
      l     = dmpt_pkg::compact(col, n, tb);
      drain = req.kind == dmpt_pkg::KIND_DRAIN;

      op.drain     = drain;
      op.wr        = drain || hit;
      op.addr      = drain ? dp : ((PW'(k) << m) | PW'(l));
      op.last      = dp == rmask;
      op.elem_real = req.elem_real;
      op.elem_imag = req.elem_imag;
   end

   always_comb begin
      load_pos_in  = load_pos_ff;
      drain_pos_in = drain_pos_ff;
      if (restart) begin
         load_pos_in  = '0;
         drain_pos_in = '0;
      end else if (accept) begin
         if (drain) begin
            drain_pos_in = (dp + PW'(1)) & rmask;
         end else begin
            load_pos_in = (lp + PW'(1)) & smask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff  <= '0;
         drain_pos_ff <= '0;
      end else begin
         load_pos_ff  <= load_pos_in;
         drain_pos_ff <= drain_pos_in;
      end
   end

endmodule

>>> rtl/dmpt_accum.sv
// Accumulator memory with read-modify-write stage, forwarding and clearing pass.
module dmpt_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  dmpt_pkg::op_type         op,
   input  logic                     adv,
   output dmpt_pkg::acc_status_type status,
   output dmpt_pkg::rsp_type        result
);

   localparam int PW = dmpt_pkg::POS_W;
   localparam int SW = dmpt_pkg::SUM_W;
   localparam int AW = dmpt_pkg::ACC_W;

   logic [AW-1:0]    mem [dmpt_pkg::ACC_DEPTH];
   dmpt_pkg::op_type s1_ff;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [AW-1:0]    rd_ff;
   logic [AW-1:0]    fwd_ff;
   logic             fwd_sel_ff;
   logic             clearing_ff;
   logic             clearing_in;
   logic [PW-1:0]    clr_addr_ff;
   logic [PW-1:0]    clr_addr_in;
   logic [AW-1:0]    operand;
   logic [AW-1:0]    wr_data;
   logic             s1_we;
   logic             fwd_hit;

   assign operand = fwd_sel_ff ? fwd_ff : rd_ff;
   assign s1_we   = adv && s1_ff.wr;
   assign fwd_hit = accept && s1_we && (s1_ff.addr == op.addr);

   always_comb begin
      if (s1_ff.drain) begin
         wr_data = '0;
      end else begin
         wr_data = {dmpt_pkg::sat_add(operand[AW-1:SW], s1_ff.elem_imag),
                    dmpt_pkg::sat_add(operand[SW-1:0], s1_ff.elem_real)};
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + PW'(1);
         if (clr_addr_ff == {PW{1'b1}}) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // stage payload and forwarding
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff      <= op;
         fwd_sel_ff <= fwd_hit;
         fwd_ff     <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (s1_we) begin
         mem[s1_ff.addr] <= wr_data;
      end
      if (accept) begin
         rd_ff <= mem[op.addr];
      end
   end

   assign status.s1_valid = s1_valid_ff;
   assign status.s1_drain = s1_ff.drain;
   assign status.clearing = clearing_ff;

   assign result.sum_real = operand[SW-1:0];
   assign result.sum_imag = operand[AW-1:SW];
   assign result.last     = s1_ff.last;

`ifndef SYNTHESIS
   a_no_stage_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff)
      else $error("stage occupied during clearing pass");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      accept |-> !clearing_ff)
      else $error("transaction accepted during clearing pass");

   a_adv_needs_item: assert property (@(posedge clock) disable iff (reset)
      adv |-> s1_valid_ff)
      else $error("advance with empty stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("stalled stage lost its item");

   a_forward_taken: assert property (@(posedge clock) disable iff (reset)
      fwd_hit |=> fwd_sel_ff)
      else $error("back-to-back same-address update not forwarded");
`endif

endmodule

>>> sim/density_matrix_partial_trace_tb.sv
// Self-checking testbench for the streaming density matrix partial trace block.
module density_matrix_partial_trace_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RANDOM_ITEMS  = 400;
   localparam int          SETTLE_CYCLES = 8;     // pipeline drain time before a register write
   localparam int          LONG_HOLD     = 400;
   localparam int          RUN_LIMIT_NS  = 2_000_000;
   localparam longint      SUM_HI        = 64'sd2147483647;
   localparam longint      SUM_LO        = -64'sd2147483648;
   localparam logic signed [dmpt_pkg::ELEM_W-1:0] ELEM_MAX = 24'sh7FFFFF;
   localparam logic signed [dmpt_pkg::ELEM_W-1:0] ELEM_MIN = 24'sh800000;

   typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_type;

   // ---------------------------------------------------------------------
   // DUT signals: every input starts at a known value
   // ---------------------------------------------------------------------
   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   dmpt_pkg::req_type              req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   dmpt_pkg::rsp_type              rsp_data;
   logic                           psel      = 1'b0;
   logic                           penable   = 1'b0;
   logic                           pwrite    = 1'b0;
   logic [dmpt_pkg::PADDR_W-1:0]   paddr     = '0;
   logic [dmpt_pkg::PDATA_W-1:0]   pwdata    = '0;
   logic [dmpt_pkg::PDATA_W-1:0]   prdata;
   logic                           pready;

   density_matrix_partial_trace DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor state: the reduced matrix sums, both positions, registers
   // ---------------------------------------------------------------------
   logic signed [dmpt_pkg::SUM_W-1:0] red_re [dmpt_pkg::ACC_DEPTH] = '{default: '0};
   logic signed [dmpt_pkg::SUM_W-1:0] red_im [dmpt_pkg::ACC_DEPTH] = '{default: '0};
   int unsigned                       load_ptr   = 0;
   int unsigned                       drain_ptr  = 0;
   logic [dmpt_pkg::QCNT_W-1:0]       qubits_reg = dmpt_pkg::QCNT_W'(1);
   logic [dmpt_pkg::MASK_W-1:0]       mask_reg   = '0;

   dmpt_pkg::rsp_type expected_sums[$];   // reduced elements still owed by the block
   dmpt_pkg::req_type pending_items[$];   // transactions waiting for the driver

   int unsigned queued_count    = 0;
   int unsigned accepted_count  = 0;
   int unsigned loads_seen      = 0;
   int unsigned drains_seen     = 0;
   int unsigned results_checked = 0;
   int unsigned settings_done   = 0;
   int unsigned clip_events     = 0;
   int unsigned fail_count      = 0;

   // Clamp n to the supported range, the way the block reads the register.
   function automatic int unsigned live_qubits();
      int unsigned n;
      n = qubits_reg;
      if (n == 0) begin
         n = 1;
      end else if (n > dmpt_pkg::MAX_QUBITS) begin
         n = dmpt_pkg::MAX_QUBITS;
      end
      return n;
   endfunction

   // Qubit q lives at index bit n-1-q; mask bits at or above n drop out.
   function automatic int unsigned traced_index_bits(int unsigned n);
      int unsigned tb;
      tb = 0;
      for (int q = 0; q < n; q++) begin
         if (mask_reg[q]) begin
            tb |= 1 << (n - 1 - q);
         end
      end
      return tb;
   endfunction

   // Remove the traced bits and close up the kept ones, low to high.
   function automatic int unsigned squeeze_index(int unsigned idx, int unsigned n,
                                                 int unsigned tb);
      int unsigned dense;
      int unsigned pos;
      dense = 0;
      pos   = 0;
      for (int b = 0; b < n; b++) begin
         if (!tb[b]) begin
            dense |= ((idx >> b) & 1) << pos;
            pos++;
         end
      end
      return dense;
   endfunction

   function automatic logic signed [dmpt_pkg::SUM_W-1:0] clip_add(
         logic signed [dmpt_pkg::SUM_W-1:0] acc,
         logic signed [dmpt_pkg::ELEM_W-1:0] elem);
      longint s;
      s = longint'(acc) + longint'(elem);
      if (s > SUM_HI) begin
         s = SUM_HI;
         clip_events++;
      end else if (s < SUM_LO) begin
         s = SUM_LO;
         clip_events++;
      end
      return s[dmpt_pkg::SUM_W-1:0];
   endfunction

   // Advance the predictor by one accepted transaction.
   function automatic void trace_accept(dmpt_pkg::req_type item);
      int unsigned       n, tb, kept, dmask, span, p, row, col, slot, rspan;
      dmpt_pkg::rsp_type want;
      n     = live_qubits();
      tb    = traced_index_bits(n);
      kept  = n - $countones(tb);
      dmask = (1 << n) - 1;
      if (item.kind == dmpt_pkg::KIND_LOAD) begin
         span = 1 << (2 * n);
         p    = load_ptr & (span - 1);
         row  = (p >> n) & dmask;
         col  = p & dmask;
         // only elements diagonal in the traced qubits contribute
         if ((row & tb) == (col & tb)) begin
            slot = ((squeeze_index(row, n, tb) << kept) | squeeze_index(col, n, tb))
                   & (dmpt_pkg::ACC_DEPTH - 1);
            red_re[slot] = clip_add(red_re[slot], item.elem_real);
            red_im[slot] = clip_add(red_im[slot], item.elem_imag);
         end
         load_ptr = (p + 1) & (span - 1);
         loads_seen++;
      end else begin
         rspan         = 1 << (2 * kept);
         p             = drain_ptr & (rspan - 1);
         want.sum_real = red_re[p];
         want.sum_imag = red_im[p];
         want.last     = (p == rspan - 1);
         red_re[p]     = '0;
         red_im[p]     = '0;
         drain_ptr     = (p + 1) & (rspan - 1);
         drains_seen++;
         expected_sums.push_back(want);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: bursts of random length separated by random gaps
   // ---------------------------------------------------------------------
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict at the edge that moves the transaction
         if (req_valid && req_ready) begin
            trace_accept(req_data);
            accepted_count++;
         end
         // hold valid and payload until accepted; only then pick what comes next
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  // a third of the bursts run straight into the next one
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Long receiver hold-off, counted here and armed once by the stimulus
   // ---------------------------------------------------------------------
   logic        hold_arm    = 1'b0;
   logic        hold_taken  = 1'b0;
   int unsigned hold_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         hold_taken  <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_arm && !hold_taken) begin
         hold_taken  <= 1'b1;
         hold_cycles <= LONG_HOLD;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each result, then pick the next ready level
   // ---------------------------------------------------------------------
   rx_mode_type rx_mode    = RX_STEADY;
   int unsigned rx_left    = 0;
   logic        ready_next = 1'b0;

   task automatic log_failure(string what, bit have_want, dmpt_pkg::rsp_type want,
                              dmpt_pkg::rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         if (have_want) begin
            $display("[%0t] %s mismatch: expected re=%0d im=%0d last=%0b,",
                     $realtime, what, want.sum_real, want.sum_imag, want.last);
            $display("    got re=%0d im=%0d last=%0b",
                     got.sum_real, got.sum_imag, got.last);
         end else begin
            $display("[%0t] %s: got re=%0d im=%0d last=%0b",
                     $realtime, what, got.sum_real, got.sum_imag, got.last);
         end
      end
   endtask

   task automatic check_result(dmpt_pkg::rsp_type got);
      dmpt_pkg::rsp_type want;
      results_checked++;
      if (expected_sums.size() == 0) begin
         log_failure("result with nothing expected", 1'b0, '0, got);
      end else begin
         want = expected_sums.pop_front();
         if (got.sum_real !== want.sum_real) log_failure("sum_real", 1'b1, want, got);
         if (got.sum_imag !== want.sum_imag) log_failure("sum_imag", 1'b1, want, got);
         if (got.last !== want.last) log_failure("last", 1'b1, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
         end
         // switch stall pattern when the current one runs out
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_left = $urandom_range(30, 150);
         end else begin
            rx_left--;
         end
         case (rx_mode)
            RX_STEADY: begin
               ready_next = 1'b1;
            end
            RX_COIN: begin
               ready_next = ($urandom_range(0, 1) == 1);
            end
            default: begin
               ready_next = ($urandom_range(0, 3) == 0);
            end
         endcase
         rsp_ready <= ready_next && (hold_cycles == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic signed [dmpt_pkg::ELEM_W-1:0] pick_elem();
      case ($urandom_range(0, 7))
         0:       return ELEM_MAX;
         1:       return ELEM_MIN;
         2:       return dmpt_pkg::ELEM_W'(int'($urandom_range(0, 8)) - 4);
         default: return dmpt_pkg::ELEM_W'($urandom);
      endcase
   endfunction

   function automatic void queue_load(logic signed [dmpt_pkg::ELEM_W-1:0] re,
                                      logic signed [dmpt_pkg::ELEM_W-1:0] im);
      dmpt_pkg::req_type item;
      item.kind      = dmpt_pkg::KIND_LOAD;
      item.elem_real = re;
      item.elem_imag = im;
      pending_items.push_back(item);
      queued_count++;
   endfunction

   // drain payloads are don't-care, so fill them with noise
   function automatic void queue_drain();
      dmpt_pkg::req_type item;
      item.kind      = dmpt_pkg::KIND_DRAIN;
      item.elem_real = dmpt_pkg::ELEM_W'($urandom);
      item.elem_imag = dmpt_pkg::ELEM_W'($urandom);
      pending_items.push_back(item);
      queued_count++;
   endfunction

   // Two-phase register write; the predictor follows at the access edge.
   task automatic csr_write(logic reg_sel, logic [dmpt_pkg::PDATA_W-1:0] value);
      logic [dmpt_pkg::PDATA_W-1:0] bus_word;
      bus_word = value;
      // unused upper bits carry junk half the time
      if ($urandom_range(0, 1)) bus_word |= $urandom & 32'hFFFF_FF00;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= bus_word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == dmpt_pkg::REG_QUBIT_COUNT) begin
         qubits_reg = value[dmpt_pkg::QCNT_W-1:0];
      end else begin
         mask_reg = value[dmpt_pkg::MASK_W-1:0];
      end
      load_ptr  = 0;
      drain_ptr = 0;
      settings_done++;
   endtask

   // Wait for every queued transaction to go in and every result to come out,
   // then let the pipeline finish any trailing load.
   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_count != queued_count || expected_sums.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(logic [dmpt_pkg::QCNT_W-1:0] qc,
                                logic [dmpt_pkg::MASK_W-1:0] mk);
      if ($urandom_range(0, 1)) begin
         csr_write(dmpt_pkg::REG_QUBIT_COUNT, dmpt_pkg::PDATA_W'(qc));
         csr_write(dmpt_pkg::REG_TRACE_MASK, dmpt_pkg::PDATA_W'(mk));
      end else begin
         csr_write(dmpt_pkg::REG_TRACE_MASK, dmpt_pkg::PDATA_W'(mk));
         csr_write(dmpt_pkg::REG_QUBIT_COUNT, dmpt_pkg::PDATA_W'(qc));
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int unsigned                 phase;
      int unsigned                 base_count;
      int unsigned                 n_live;
      int unsigned                 kept;
      int unsigned                 drains;
      logic [dmpt_pkg::QCNT_W-1:0] qc;
      logic [dmpt_pkg::MASK_W-1:0] mk;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: one qubit, nothing traced. Full-scale corners, then a fifth
      // load that wraps the load position back onto element zero.
      apply_setting(dmpt_pkg::QCNT_W'(1), dmpt_pkg::MASK_W'(0));
      queue_load(ELEM_MAX, ELEM_MIN);
      queue_load(ELEM_MIN, ELEM_MAX);
      queue_load('0, '0);
      queue_load(-24'sd1, 24'sd1);
      queue_load(24'sd1, -24'sd1);
      repeat (4) queue_drain();
      wait_idle();

      // Directed: count of zero reads as one, mask wider than n traces all,
      // so the reduced matrix is 1x1; the second drain wraps and reads zero.
      apply_setting(dmpt_pkg::QCNT_W'(0), dmpt_pkg::MASK_W'(63));
      queue_load(ELEM_MAX, ELEM_MAX);
      queue_load(24'sd5, -24'sd5);
      queue_load(-24'sd7, 24'sd7);
      queue_load(ELEM_MIN, ELEM_MIN);
      repeat (2) queue_drain();
      wait_idle();

      // Directed: count above the maximum clamps to six; keep only qubit 0.
      // Leave it half done so the next write restarts both positions.
      apply_setting(dmpt_pkg::QCNT_W'(7), dmpt_pkg::MASK_W'(62));
      repeat (6) queue_load(pick_elem(), pick_elem());
      repeat (3) queue_drain();
      wait_idle();

      // Random phases: mostly whole matrices loaded then drained, with stray
      // transactions mixed in; large n gets short broken sequences instead.
      base_count = queued_count;
      phase      = 0;
      while (queued_count - base_count < RANDOM_ITEMS) begin
         if (phase == 0) begin
            qc = dmpt_pkg::QCNT_W'(3);
            mk = '0;
         end else begin
            qc = dmpt_pkg::QCNT_W'($urandom_range(0, 7));
            mk = dmpt_pkg::MASK_W'($urandom_range(0, 63));
         end
         apply_setting(qc, mk);
         n_live = live_qubits();
         kept   = n_live - $countones(traced_index_bits(n_live));
         if (phase == 0 || (n_live <= 3 && $urandom_range(0, 4) != 0)) begin
            repeat (1 << (2 * n_live)) begin
               if ($urandom_range(0, 19) == 0) queue_drain();
               queue_load(pick_elem(), pick_elem());
            end
            drains = 1 << (2 * kept);
            if (phase != 0 && $urandom_range(0, 5) == 0) drains = $urandom_range(1, drains);
            repeat (drains) begin
               if ($urandom_range(0, 19) == 0) queue_load(pick_elem(), pick_elem());
               queue_drain();
            end
         end else begin
            repeat ($urandom_range(8, 40)) begin
               if ($urandom_range(0, 3) == 0) begin
                  queue_drain();
               end else begin
                  queue_load(pick_elem(), pick_elem());
               end
            end
         end
         // first phase: stall the receiver long enough that drains back up
         if (phase == 0) hold_arm <= 1'b1;
         wait_idle();
         phase++;
      end

      repeat (20) @(posedge clock);
      if (expected_sums.size() != 0) begin
         $display("%0d expected results never arrived", expected_sums.size());
         fail_count += expected_sums.size();
      end

      $display("Covered %0d loads and %0d drains over %0d register writes,",
               loads_seen, drains_seen, settings_done);
      $display("%0d clipped sums; checked %0d results, %0d failures.",
               clip_events, results_checked, fail_count);
      if (fail_count == 0) begin
         $display("density_matrix_partial_trace_tb passed");
      end else begin
         $display("density_matrix_partial_trace_tb failed");
      end
      $finish;
   end

   // Hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("density_matrix_partial_trace_tb failed");
      $finish;
   end

endmodule
